// ===== rtl/mlfqs_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfqs_pkg
// Shared types, constants and fixed-point helpers of the MLFQS priority engine.
// ----------------------------------------------------------------------------
package mlfqs_pkg;

    localparam int NUM_THREADS_DEF = 16;
    localparam int FRAC_BITS       = 14;
    localparam int FRAC_ONE        = 1 << FRAC_BITS;

    localparam logic [FRAC_BITS-1:0] LOAD_DECAY = FRAC_BITS'((59 * FRAC_ONE) / 60);
    localparam logic [8:0]           LOAD_GAIN  = 9'(FRAC_ONE / 60);

    localparam logic [9:0] TPS_RESET    = 10'd100;
    localparam logic [7:0] SLICE_RESET  = 8'd4;
    localparam logic [7:0] PERIOD_RESET = 8'd4;

    typedef enum logic [2:0] {
        OP_TICK, OP_CREATE, OP_EXIT, OP_SET_NICE, OP_SWITCH, OP_QUERY
    } op_t;

    typedef enum logic [1:0] {
        CFG_TPS, CFG_SLICE, CFG_PERIOD
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_DIV, ST_DEC_RD, ST_DEC_MUL, ST_DEC_WR,
        ST_LOAD_MUL, ST_LOAD_WR, ST_PRI_RD, ST_PRI_WR, ST_REP_RD,
        ST_REP_CALC, ST_OUT
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic div_load;
        logic div_step;
    } alu_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > $signed(36'h0_7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (v < $signed(36'hF_8000_0000)) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // 63 - round(rc/4) - 2*nice, clamped to 0..63
    function automatic logic [5:0] calc_priority(input logic signed [31:0] rc,
                                                 input logic signed [5:0] nice);
        logic [32:0]        mag;
        logic [16:0]        r;
        logic signed [19:0] rs;
        logic signed [19:0] ne;
        logic signed [19:0] p;
        mag = rc[31] ? (33'd0 - {rc[31], rc}) : {1'b0, rc};
        r   = 17'(((mag >> 2) + 33'(FRAC_ONE / 2)) >> FRAC_BITS);
        rs  = rc[31] ? -$signed({3'b0, r}) : $signed({3'b0, r});
        ne  = {{13{nice[5]}}, nice, 1'b0};
        p   = 20'sd63 - rs - ne;
        if (p < 0) begin
            return 6'd0;
        end else if (p > 20'sd63) begin
            return 6'd63;
        end
        return p[5:0];
    endfunction

    // 100*v rounded half away from zero
    function automatic logic signed [31:0] round_x100(input logic signed [31:0] v);
        logic [38:0] xs;
        logic [38:0] x;
        logic [38:0] mag;
        logic [31:0] r;
        xs  = {{7{v[31]}}, v};
        x   = (xs << 6) + (xs << 5) + (xs << 2);
        mag = x[38] ? (39'd0 - x) : x;
        r   = 32'((mag + 39'(FRAC_ONE / 2)) >> FRAC_BITS);
        return x[38] ? $signed(32'd0 - r) : $signed(r);
    endfunction

endpackage

// ===== rtl/mlfqs_alu.sv =====
// ----------------------------------------------------------------------------
// mlfqs_alu
// Shared multiplier with registered product and a radix-2 restoring divider
// that yields the cpu usage decay coefficient one bit per step.
// ----------------------------------------------------------------------------
module mlfqs_alu (
    input  logic                                  aclk,
    input  mlfqs_pkg::alu_ctrl_t                  ctrl,
    input  logic [mlfqs_pkg::FRAC_BITS-1:0]       mul_a,
    input  logic signed [32:0]                    mul_b,
    input  logic [32:0]                           div_num,
    output logic signed [47:0]                    prod,
    output logic [mlfqs_pkg::FRAC_BITS-1:0]       quot
);
    import mlfqs_pkg::*;

    logic signed [47:0]    prod_reg;
    logic signed [47:0]    prod_next;
    logic [33:0]           rem_reg;
    logic [33:0]           rem_next;
    logic [33:0]           rem_sh;
    logic [32:0]           den_reg;
    logic [32:0]           den_next;
    logic [FRAC_BITS-1:0]  quot_reg;
    logic [FRAC_BITS-1:0]  quot_next;

    always_comb begin
        prod_next = $signed({1'b0, mul_a}) * mul_b;
        rem_sh    = {rem_reg[32:0], 1'b0};
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (ctrl.div_load) begin
            // remainder starts below the divisor, so the quotient fits FRAC_BITS
            rem_next  = {1'b0, div_num};
            den_next  = div_num + 33'(FRAC_ONE);
            quot_next = '0;
        end else if (ctrl.div_step) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next  = rem_sh - {1'b0, den_reg};
                quot_next = {quot_reg[FRAC_BITS-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                quot_next = {quot_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign prod = prod_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/mlfqs_priority_engine_unit.sv =====
// ----------------------------------------------------------------------------
// mlfqs_priority_engine_unit
// Thread table with nice, cpu usage and priority, a load average and tick
// phases; one sequencer drives a shared multiply/divide unit over the table.
// ----------------------------------------------------------------------------
// Sequence: every operation passes through execute, report read, report calc and
// result states. A per-second tick adds the divider steps, a read, multiply and
// write per thread for the decay, and a load multiply and write; a priority
// recompute adds a read and a write per thread (table read port bound).
// Flow: one item at a time; the next may be taken in the cycle after the result beat.
// Reset: sync active-low aresetn empties the table, clears load, phases; no clearing pass.
module mlfqs_priority_engine_unit #(
    parameter int NUM_THREADS = mlfqs_pkg::NUM_THREADS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic [3:0]         s_thread_index,
    input  logic [3:0]         s_parent_index,
    input  logic signed [5:0]  s_nice_value,
    input  logic [5:0]         s_initial_priority,
    input  logic               s_running_is_idle,
    input  logic [4:0]         s_ready_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_priority_res,
    output logic signed [5:0]  m_nice_out,
    output logic signed [31:0] m_cpu_usage_x100,
    output logic [30:0]        m_sys_load_x100,
    output logic               m_preempt,
    output logic               m_status
);
    import mlfqs_pkg::*;

    localparam int IDX_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_THREADS - 1);

    state_t state_reg, state_next;

    logic signed [5:0]  nice_mem [NUM_THREADS];
    logic signed [31:0] rc_mem   [NUM_THREADS];
    logic [5:0]         pri_mem  [NUM_THREADS];
    logic [NUM_THREADS-1:0] valid_reg;

    logic signed [5:0]  rd_nice_reg;
    logic signed [31:0] rd_rc_reg;
    logic [5:0]         rd_pri_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic               nice_we, rc_we, pri_we;
    logic [IDX_W-1:0]   wr_addr;
    logic signed [5:0]  nice_wdata;
    logic signed [31:0] rc_wdata;
    logic [5:0]         pri_wdata;

    logic [9:0] tps_reg;
    logic [7:0] slice_lim_reg;
    logic [7:0] period_reg;
    logic [30:0] load_reg;
    logic [9:0] second_reg;
    logic [7:0] pphase_reg;
    logic [7:0] slice_reg;

    logic [2:0]        op_reg;
    logic [3:0]        ti_reg;
    logic [3:0]        pi_reg;
    logic signed [5:0] nv_reg;
    logic [5:0]        ip_reg;
    logic              idle_reg;
    logic [4:0]        ready_cnt_reg;

    logic status_reg, preempt_reg, pri_fire_reg;
    logic [IDX_W-1:0] walk_reg;
    logic [3:0]       cnt_reg;

    logic [5:0]         out_pri_reg;
    logic signed [5:0]  out_nice_reg;
    logic signed [31:0] out_rc_reg;
    logic [30:0]        out_load_reg;

    alu_ctrl_t            alu_ctrl;
    logic [FRAC_BITS-1:0] mul_a;
    logic signed [32:0]   mul_b;
    logic signed [47:0]   prod;
    logic [FRAC_BITS-1:0] quot;

    logic [IDX_W-1:0]   ti_idx;
    logic               ti_in, ok_w, parent_ok, walk_valid, walk_last;
    logic [7:0]         slice_inc;
    logic               sec_hit, pri_hit;
    logic               exec_status;
    logic signed [5:0]  nv_cl;
    logic signed [47:0] dec_rnd;
    logic signed [47:0] dec_q;
    logic signed [35:0] dec_sum;
    logic [13:0]        gain_term;
    logic [35:0]        load_sum;
    logic [37:0]        load_x;

    assign ti_idx     = IDX_W'(ti_reg);
    assign ti_in      = 32'(ti_reg) < NUM_THREADS;
    assign ok_w       = ti_in && valid_reg[ti_idx];
    assign parent_ok  = (32'(pi_reg) < NUM_THREADS) && valid_reg[IDX_W'(pi_reg)];
    assign walk_valid = valid_reg[walk_reg];
    assign walk_last  = walk_reg == LAST_IDX;
    assign slice_inc  = (slice_reg == 8'hFF) ? slice_reg : slice_reg + 8'd1;
    assign sec_hit    = ({1'b0, second_reg} + 11'd1) >= {1'b0, tps_reg};
    assign pri_hit    = ({1'b0, pphase_reg} + 9'd1) >= {1'b0, period_reg};

    always_comb begin
        if (nv_reg < -6'sd20) begin
            nv_cl = -6'sd20;
        end else if (nv_reg > 6'sd20) begin
            nv_cl = 6'sd20;
        end else begin
            nv_cl = nv_reg;
        end
    end

    always_comb begin
        case (op_reg)
            OP_TICK:   exec_status = !idle_reg && !ok_w;
            OP_CREATE: exec_status = !ti_in;
            default:   exec_status = !ok_w;
        endcase
    end

    // decay: truncate coef*rc toward zero, add nice, saturate
    assign dec_rnd = prod + (prod[47] ? 48'sd16383 : 48'sd0);
    assign dec_q   = dec_rnd >>> FRAC_BITS;
    assign dec_sum = 36'(dec_q)
                   + $signed({{(30 - FRAC_BITS){rd_nice_reg[5]}}, rd_nice_reg,
                              {FRAC_BITS{1'b0}}});

    assign gain_term = {5'b0, LOAD_GAIN} * {9'b0, ready_cnt_reg};
    assign load_sum  = {2'b0, prod[47:FRAC_BITS]} + {22'b0, gain_term};
    assign load_x    = (38'(load_reg) << 6) + (38'(load_reg) << 5) + (38'(load_reg) << 2);

    mlfqs_alu u_alu (
        .aclk    (aclk),
        .ctrl    (alu_ctrl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .div_num ({1'b0, load_reg, 1'b0}),
        .prod    (prod),
        .quot    (quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (op_reg == OP_TICK && sec_hit) begin
                    state_next = ST_DIV;
                end else if (op_reg == OP_TICK && pri_hit) begin
                    state_next = ST_PRI_RD;
                end else begin
                    state_next = ST_REP_RD;
                end
            end
            ST_DIV: begin
                if (cnt_reg == 4'(FRAC_BITS - 1)) state_next = ST_DEC_RD;
            end
            ST_DEC_RD:  state_next = ST_DEC_MUL;
            ST_DEC_MUL: state_next = ST_DEC_WR;
            ST_DEC_WR:  state_next = walk_last ? ST_LOAD_MUL : ST_DEC_RD;
            ST_LOAD_MUL: state_next = ST_LOAD_WR;
            ST_LOAD_WR: state_next = pri_fire_reg ? ST_PRI_RD : ST_REP_RD;
            ST_PRI_RD:  state_next = ST_PRI_WR;
            ST_PRI_WR:  state_next = walk_last ? ST_REP_RD : ST_PRI_RD;
            ST_REP_RD:  state_next = ST_REP_CALC;
            ST_REP_CALC: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        alu_ctrl   = '0;
        mul_a      = quot;
        mul_b      = {rd_rc_reg[31], rd_rc_reg};
        rd_addr    = ti_idx;
        nice_we    = 1'b0;
        rc_we      = 1'b0;
        pri_we     = 1'b0;
        wr_addr    = ti_idx;
        nice_wdata = nv_cl;
        rc_wdata   = sat32(36'(rd_rc_reg) + 36'(FRAC_ONE));
        pri_wdata  = calc_priority(rd_rc_reg, nv_cl);
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = (s_operation == OP_CREATE) ? IDX_W'(s_parent_index)
                                                     : IDX_W'(s_thread_index);
            end
            ST_EXEC: begin
                alu_ctrl.div_load = (op_reg == OP_TICK) && sec_hit;
                case (op_reg)
                    OP_TICK: begin
                        rc_we = !idle_reg && ok_w;
                    end
                    OP_CREATE: begin
                        nice_we    = ti_in;
                        rc_we      = ti_in;
                        pri_we     = ti_in;
                        nice_wdata = parent_ok ? rd_nice_reg : 6'sd0;
                        rc_wdata   = parent_ok ? rd_rc_reg : 32'sd0;
                        pri_wdata  = ip_reg;
                    end
                    OP_SET_NICE: begin
                        nice_we = ok_w;
                        pri_we  = ok_w;
                    end
                    default: ;
                endcase
            end
            ST_DIV: alu_ctrl.div_step = 1'b1;
            ST_DEC_RD: rd_addr = walk_reg;
            ST_DEC_MUL: begin
                rd_addr         = walk_reg;
                alu_ctrl.mul_en = 1'b1;
            end
            ST_DEC_WR: begin
                rd_addr  = walk_reg;
                rc_we    = walk_valid;
                wr_addr  = walk_reg;
                rc_wdata = sat32(dec_sum);
            end
            ST_LOAD_MUL: begin
                alu_ctrl.mul_en = 1'b1;
                mul_a           = LOAD_DECAY;
                mul_b           = {2'b0, load_reg};
            end
            ST_LOAD_WR: ;
            ST_PRI_RD: rd_addr = walk_reg;
            ST_PRI_WR: begin
                rd_addr   = walk_reg;
                pri_we    = walk_valid;
                wr_addr   = walk_reg;
                pri_wdata = calc_priority(rd_rc_reg, rd_nice_reg);
            end
            ST_REP_RD: ;
            ST_REP_CALC: ;
            ST_OUT: m_valid = 1'b1;
            default: ;
        endcase
    end

    // table storage: one write and one registered read per array
    always_ff @(posedge aclk) begin
        if (nice_we) nice_mem[wr_addr] <= nice_wdata;
        if (rc_we)   rc_mem[wr_addr]   <= rc_wdata;
        if (pri_we)  pri_mem[wr_addr]  <= pri_wdata;
        rd_nice_reg <= nice_mem[rd_addr];
        rd_rc_reg   <= rc_mem[rd_addr];
        rd_pri_reg  <= pri_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            tps_reg       <= TPS_RESET;
            slice_lim_reg <= SLICE_RESET;
            period_reg    <= PERIOD_RESET;
            load_reg      <= '0;
            second_reg    <= '0;
            pphase_reg    <= '0;
            slice_reg     <= '0;
            status_reg    <= 1'b0;
            preempt_reg   <= 1'b0;
            pri_fire_reg  <= 1'b0;
            walk_reg      <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_TPS:    tps_reg       <= cfg_wdata;
                    CFG_SLICE:  slice_lim_reg <= cfg_wdata[7:0];
                    CFG_PERIOD: period_reg    <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_EXEC: begin
                    walk_reg     <= '0;
                    cnt_reg      <= '0;
                    status_reg   <= exec_status;
                    preempt_reg  <= (op_reg == OP_TICK) && (slice_inc >= slice_lim_reg);
                    pri_fire_reg <= (op_reg == OP_TICK) && pri_hit;
                    case (op_reg)
                        OP_TICK: begin
                            slice_reg    <= slice_inc;
                            second_reg   <= sec_hit ? 10'd0 : second_reg + 10'd1;
                            pphase_reg   <= pri_hit ? 8'd0 : pphase_reg + 8'd1;
                        end
                        OP_CREATE: begin
                            if (ti_in) valid_reg[ti_idx] <= 1'b1;
                        end
                        OP_SWITCH: slice_reg <= '0;
                        default: ;
                    endcase
                end
                ST_DIV: cnt_reg <= cnt_reg + 4'd1;
                ST_DEC_WR: begin
                    walk_reg <= walk_last ? '0 : walk_reg + IDX_W'(1);
                end
                ST_LOAD_WR: begin
                    load_reg <= (load_sum > 36'h0_7FFF_FFFF) ? 31'h7FFF_FFFF
                                                             : load_sum[30:0];
                end
                ST_PRI_WR: begin
                    walk_reg <= walk_last ? '0 : walk_reg + IDX_W'(1);
                end
                ST_REP_CALC: begin
                    // drop the entry in the same cycle its values are captured for the result
                    if (op_reg == OP_EXIT && ok_w) valid_reg[ti_idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload capture and result registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg        <= s_operation;
            ti_reg        <= s_thread_index;
            pi_reg        <= s_parent_index;
            nv_reg        <= s_nice_value;
            ip_reg        <= s_initial_priority;
            idle_reg      <= s_running_is_idle;
            ready_cnt_reg <= s_ready_count;
        end
        if (state_reg == ST_REP_CALC) begin
            out_pri_reg  <= ok_w ? rd_pri_reg : 6'd0;
            out_nice_reg <= ok_w ? rd_nice_reg : 6'sd0;
            out_rc_reg   <= ok_w ? round_x100(rd_rc_reg) : 32'sd0;
            out_load_reg <= 31'((load_x + 38'(FRAC_ONE / 2)) >> FRAC_BITS);
        end
    end

    assign m_priority_res    = out_pri_reg;
    assign m_nice_out        = out_nice_reg;
    assign m_cpu_usage_x100  = out_rc_reg;
    assign m_sys_load_x100   = out_load_reg;
    assign m_preempt         = preempt_reg;
    assign m_status          = status_reg;

endmodule
